### sv/bda_pkg.sv
// Shared types and constants for the box average downsampler.
package bda_pkg;

    localparam int MAX_SRC_DIM = 4096;
    localparam int MAX_DST_DIM = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int DIM_W       = 13;
    localparam int COL_W       = 12;
    localparam int SUM_W       = 48;
    localparam int SQ_W        = 2 * COL_W;
    localparam int QCNT_W      = 6;

    localparam logic REG_SRC = 1'b0;
    localparam logic REG_DST = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_ACC, S_DST, S_DWAIT,
        S_CSTEP, S_CSTEPW, S_CGRID, S_CGRIDW, S_CLIM
    } t_state;

    typedef enum logic [1:0] {
        DSEL_STEP, DSEL_GRID, DSEL_BLOCK
    } t_dsel;

    typedef struct packed {
        logic  take;
        logic  upd;
        logic  acc;
        logic  div_start;
        t_dsel div_sel;
        logic  ld_st;
        logic  ld_nb;
        logic  ld_lim;
        logic  ld_out;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic div_busy;
        logic emit;
        logic out_busy;
    } t_sts;

endpackage

### sv/bda_ram.sv
// Generic single-port RAM with registered read.
module bda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### sv/bda_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module bda_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bda_pkg::SUM_W-1:0]   i_dividend,
    input  logic [bda_pkg::SQ_W-1:0]    i_divisor,
    output logic                        o_busy,
    output logic [bda_pkg::SUM_W-1:0]   o_quotient
);
    import bda_pkg::*;

    logic              r_busy;
    logic [QCNT_W-1:0] r_cnt;
    logic [SQ_W:0]     r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [SQ_W-1:0]   r_dvs;
    logic [SQ_W:0]     trial;
    logic              ge;

    always_comb begin
        trial = {r_rem[SQ_W-1:0], r_quo[SUM_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= QCNT_W'(SUM_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

### sv/bda_ctrl.sv
// Sequencing state machine for configuration setup and sample processing.
module bda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bda_pkg::t_sts i_sts,
    output logic          o_ready,
    output bda_pkg::t_cmd o_cmd
);
    import bda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_RD;
            S_RD:     n_state = S_ACC;
            S_ACC:    n_state = i_sts.emit ? S_DST : S_IDLE;
            S_DST:    n_state = S_DWAIT;
            S_DWAIT:  if (!i_sts.div_busy && !i_sts.out_busy) n_state = S_IDLE;
            S_CSTEP:  n_state = S_CSTEPW;
            S_CSTEPW: if (!i_sts.div_busy) n_state = S_CGRID;
            S_CGRID:  n_state = S_CGRIDW;
            S_CGRIDW: if (!i_sts.div_busy) n_state = S_CLIM;
            S_CLIM:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (i_sts.cfg_wr) begin
            n_state = S_CSTEP;
        end
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        o_cmd.div_sel = DSEL_BLOCK;
        unique case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.take = i_valid;
            end
            S_RD:  o_cmd.upd = 1'b1;
            S_ACC: o_cmd.acc = 1'b1;
            S_DST: o_cmd.div_start = 1'b1;
            S_DWAIT: o_cmd.ld_out = !i_sts.div_busy && !i_sts.out_busy;
            S_CSTEP: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_STEP;
            end
            S_CSTEPW: o_cmd.ld_st = !i_sts.div_busy;
            S_CGRID: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_GRID;
            end
            S_CGRIDW: o_cmd.ld_nb = !i_sts.div_busy;
            S_CLIM:   o_cmd.ld_lim = 1'b1;
            default: ;
        endcase
    end
endmodule

### sv/bda_dp.sv
// Datapath: raster counters, column sum line, block sum, divider and result register.
module bda_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bda_pkg::t_cmd                   i_cmd,
    output bda_pkg::t_sts                   o_sts,
    input  logic                            i_cfg_wr,
    input  logic                            i_cfg_idx,
    input  logic [bda_pkg::DIM_W-1:0]       i_cfg_data,
    output logic [bda_pkg::DIM_W-1:0]       o_src_dim,
    output logic [bda_pkg::DIM_W-1:0]       o_dst_dim,
    input  logic [bda_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bda_pkg::SAMPLE_BITS-1:0] o_avg,
    output logic                            o_last
);
    import bda_pkg::*;

    logic [DIM_W-1:0]       r_src, r_dst, s_eff, d_eff;
    logic [COL_W-1:0]       r_st, r_col, r_row, r_cm, r_rm;
    logic [DIM_W-1:0]       r_nb, r_lim;
    logic [SQ_W-1:0]        r_sq;
    logic [SUM_W-1:0]       r_smp, r_new, r_hsum;
    logic                   r_first, r_emit, r_last, r_neg;
    logic                   r_out_valid, r_out_last;
    logic [SAMPLE_BITS-1:0] r_out_avg;

    logic [SUM_W-1:0] ram_rdata, dvd, quo;
    logic [SQ_W-1:0]  dvs;
    logic             div_busy, in_grid, ram_we;
    logic [DIM_W-1:0] col_nx, row_nx;
    logic [COL_W-1:0] st_m1;

    always_comb begin
        s_eff = r_src;
        if (r_src == '0) s_eff = DIM_W'(1);
        if (r_src > DIM_W'(MAX_SRC_DIM)) s_eff = DIM_W'(MAX_SRC_DIM);
        d_eff = r_dst;
        if (r_dst < DIM_W'(2)) d_eff = DIM_W'(2);
        if (r_dst > DIM_W'(MAX_DST_DIM)) d_eff = DIM_W'(MAX_DST_DIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= DIM_W'(2);
            r_dst <= DIM_W'(2);
        end else if (i_cfg_wr) begin
            if (i_cfg_idx == REG_SRC) r_src <= i_cfg_data;
            else                      r_dst <= i_cfg_data;
        end
    end

    always_comb begin
        dvd = '0;
        dvs = '0;
        case (i_cmd.div_sel)
            DSEL_STEP: begin
                dvd = SUM_W'(s_eff - 1'b1);
                dvs = SQ_W'(d_eff - 1'b1);
            end
            DSEL_GRID: begin
                dvd = SUM_W'(s_eff);
                dvs = SQ_W'(r_st);
            end
            default: begin
                dvd = r_hsum[SUM_W-1] ? (~r_hsum + 1'b1) : r_hsum;
                dvs = r_sq;
            end
        endcase
    end

    bda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= COL_W'(1);
            r_nb  <= DIM_W'(2);
            r_lim <= DIM_W'(2);
            r_sq  <= SQ_W'(1);
        end else begin
            if (i_cmd.ld_st) r_st <= (quo == '0) ? COL_W'(1) : quo[COL_W-1:0];
            if (i_cmd.ld_nb) r_nb <= (quo[DIM_W-1:0] < d_eff) ? quo[DIM_W-1:0] : d_eff;
            if (i_cmd.ld_lim) begin
                r_lim <= DIM_W'(r_nb * r_st);
                r_sq  <= SQ_W'(r_st) * SQ_W'(r_st);
            end
        end
    end

    assign st_m1   = r_st - 1'b1;
    assign in_grid = ({1'b0, r_col} < r_lim) && ({1'b0, r_row} < r_lim);
    assign col_nx  = {1'b0, r_col} + 1'b1;
    assign row_nx  = {1'b0, r_row} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cm  <= '0;
            r_rm  <= '0;
        end else if (i_cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
            r_cm  <= '0;
            r_rm  <= '0;
        end else if (i_cmd.upd) begin
            if (col_nx >= s_eff) begin
                r_col <= '0;
                r_cm  <= '0;
                if (row_nx >= s_eff) begin
                    r_row <= '0;
                    r_rm  <= '0;
                end else begin
                    r_row <= row_nx[COL_W-1:0];
                    r_rm  <= (r_rm == st_m1) ? '0 : r_rm + 1'b1;
                end
            end else begin
                r_col <= col_nx[COL_W-1:0];
                r_cm  <= (r_cm == st_m1) ? '0 : r_cm + 1'b1;
            end
        end
    end

    assign ram_we = i_cmd.upd && in_grid;

    bda_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SRC_DIM)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_col),
        .i_wdata ((r_rm == '0) ? r_smp : ram_rdata + r_smp),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_smp <= SUM_W'(signed'(i_sample));
        if (i_cmd.upd) begin
            r_new   <= (r_rm == '0) ? r_smp : ram_rdata + r_smp;
            r_first <= (r_cm == '0);
            r_emit  <= in_grid && (r_rm == st_m1) && (r_cm == st_m1);
            r_last  <= ({1'b0, r_col} == r_lim - 1'b1) && ({1'b0, r_row} == r_lim - 1'b1);
        end
        if (i_cmd.acc) r_hsum <= r_first ? r_new : r_hsum + r_new;
        if (i_cmd.div_start) r_neg <= r_hsum[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_avg  <= r_neg ? (~quo[SAMPLE_BITS-1:0] + 1'b1) : quo[SAMPLE_BITS-1:0];
            r_out_last <= r_last;
        end
    end

    always_comb begin
        o_sts.cfg_wr   = i_cfg_wr;
        o_sts.div_busy = div_busy;
        o_sts.emit     = r_emit;
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_src_dim   = r_src;
    assign o_dst_dim   = r_dst;
    assign o_out_valid = r_out_valid;
    assign o_avg       = r_out_avg;
    assign o_last      = r_out_last;
endmodule

### sv/box_average_downsampler.sv
// Top level of the box average downsampler.
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_ready    | i_sample_height
//  output  | out       | o_valid / i_ready    | o_block_average, o_last_block
//  config  | in        | psel/penable/pwrite  | paddr, pwdata, prdata
// A word is taken, added to its column line sum and then to the block sum; a word that
// closes a block then runs the 48-step quotient of the block sum by step^2.
// A config write runs two divisions and the limit multiply.
// Reset is synchronous; the column line holds no reset value and is always
// written before being read. A full result register stalls the divide exit only.
module box_average_downsampler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bda_pkg::SAMPLE_BITS-1:0] i_sample_height,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bda_pkg::SAMPLE_BITS-1:0] o_block_average,
    output logic                            o_last_block,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bda_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic             cfg_wr;
    logic [DIM_W-1:0] src_dim, dst_dim;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SRC) ? 32'(src_dim) : 32'(dst_dim);

    bda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    bda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_idx   (paddr[2]),
        .i_cfg_data  (pwdata[DIM_W-1:0]),
        .o_src_dim   (src_dim),
        .o_dst_dim   (dst_dim),
        .i_sample    (i_sample_height),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_avg       (o_block_average),
        .o_last      (o_last_block)
    );

    a_take_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !cfg_wr) |=> !o_ready)
        else $error("input accepted but controller stayed ready");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> sts.div_busy)
        else $error("divider did not start");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ld_out |-> !(o_valid && !i_ready))
        else $error("result register overwritten");
endmodule
